// File: hdl/htw_pkg.sv
// Shared types and codes for the hashed timing wheel.
package htw_pkg;

  // Fixed field widths of the item and register formats.
  localparam int DLY_W    = 31;
  localparam int IVL_W    = 20;
  localparam int SCNT_W   = 7;
  localparam int HANDLE_W = 16;
  localparam int STAT_W   = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DCNT_W   = 5;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_POOL_FULL = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_REMOVED   = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_EXPIRED   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INTERVAL = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SCNT_W-1:0] SLOT_COUNT_RST    = 7'd60;
  localparam logic [IVL_W-1:0]  SLOT_INTERVAL_RST = 20'd1000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DLY_W-1:0]  delay_ms;
    logic [HANDLE_W-1:0] target_id;
  } htw_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] timer_handle;
    logic                last;
  } htw_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE,
    ST_MOD,
    ST_DIV1,
    ST_DIV2,
    ST_ADD_WR,
    ST_EMIT,
    ST_RM_RD,
    ST_RM_CHK,
    ST_TK_RD,
    ST_TK_CHK,
    ST_EX_SCAN,
    ST_EX_RD,
    ST_EX_OUT
  } htw_state_t;

endpackage

// File: hdl/hashed_timing_wheel.sv
// Hashed timing wheel: timer pool, wheel sequencer and shared divider.
//
// Usage notes: items are handled one at a time; in_ready is high only while
// the sequencer is idle, and a result waits in the output register without
// holding up the next item. All division and modulo run through one
// restoring divider that retires one quotient bit per cycle, and the timer
// pool memory is read one entry at a time, each read followed by a check.
// An add scans for the lowest free entry, then reduces the current slot
// modulo the slots in use, divides delay by interval, splits the quotient
// into rotations and slot, writes the new entry and emits its result. A
// remove reads and compares each entry in turn. A tick reduces the current
// slot, reads and checks each entry, and then for each timer that expires
// scans for the newest remaining one. A pool-full add answers once the
// whole pool has been scanned.
module hashed_timing_wheel #(
  parameter int MAX_SLOTS  = 64,
  parameter int MAX_TIMERS = 32,
  parameter int ID_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  htw_pkg::htw_in_t                    in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output htw_pkg::htw_out_t                   out_item,
  input  logic                                cfg_we,
  input  logic [htw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htw_pkg::IVL_W-1:0]           cfg_wdata
);

  import htw_pkg::*;

  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SUM_W = (SLOT_W + 1 > 8) ? SLOT_W + 1 : 8;
  localparam int HID_W = (ID_BITS > HANDLE_W) ? ID_BITS : HANDLE_W;

  // Sequencer and control registers.
  htw_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    free_r, free_nxt;
  logic [KIND_W-1:0]   op_r, op_nxt;
  logic [DLY_W-1:0]    delay_r, delay_nxt;
  logic [HANDLE_W-1:0] target_r, target_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOT_W-1:0]   current_slot_r, current_slot_nxt;
  logic [ID_BITS-1:0]  next_ident_r, next_ident_nxt;
  logic [SCNT_W-1:0]   slot_count_r;
  logic [IVL_W-1:0]    interval_r;

  // Shared divider registers.
  logic [DLY_W-1:0]    dq_r, dq_nxt;
  logic [IVL_W-1:0]    rem_r, rem_nxt;
  logic [IVL_W-1:0]    dvs_r, dvs_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;

  // Expiry bookkeeping.
  logic [MAX_TIMERS-1:0] due_r, due_nxt;
  logic [CNT_W-1:0]      due_cnt_r, due_cnt_nxt;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic [IDX_W-1:0]      best_age_r, best_age_nxt;
  logic                  best_vld_r, best_vld_nxt;

  // Pending single result of an add or remove.
  logic [STAT_W-1:0]   emit_status_r, emit_status_nxt;
  logic [HANDLE_W-1:0] emit_handle_r, emit_handle_nxt;

  // Output register.
  logic     out_valid_r, out_valid_nxt;
  htw_out_t out_item_r, out_item_nxt;
  logic     out_free;
  logic     out_load;
  htw_out_t out_load_item;

  // Per-entry flags and ages in flip-flops.
  logic [MAX_TIMERS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      age_r   [MAX_TIMERS];
  logic [IDX_W-1:0]      age_nxt [MAX_TIMERS];

  // Timer pool memory.
  logic [ID_BITS-1:0] mem_ident  [MAX_TIMERS];
  logic [SLOT_W-1:0]  mem_slot   [MAX_TIMERS];
  logic [DLY_W-1:0]   mem_rounds [MAX_TIMERS];
  logic [ID_BITS-1:0] rd_ident_r;
  logic [SLOT_W-1:0]  rd_slot_r;
  logic [DLY_W-1:0]   rd_rounds_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ID_BITS-1:0] mem_wident;
  logic [SLOT_W-1:0]  mem_wslot;
  logic [DLY_W-1:0]   mem_wrounds;

  // Pool update requests from the sequencer.
  logic add_en;
  logic rel_en;
  logic due_set;
  logic due_clr;

  // Effective configuration.
  logic [SCNT_W-1:0] slots_use;
  logic [IVL_W-1:0]  interval_use;

  // Values read at the scan index.
  logic             valid_at;
  logic             due_at;
  logic [IDX_W-1:0] age_at;
  logic             idx_last;

  // Divider step.
  logic [IVL_W:0]   div_shift;
  logic [IVL_W+1:0] div_diff;
  logic             div_ge;
  logic [IVL_W-1:0] rem_step;
  logic [DLY_W-1:0] dq_step;
  logic             div_last;

  // Slot arithmetic and identifiers.
  logic [SUM_W-1:0]   slot_sum;
  logic [SUM_W-1:0]   slot_wrap;
  logic [SUM_W-1:0]   cur_inc;
  logic [SUM_W-1:0]   cur_wrap;
  logic [ID_BITS-1:0] ident_inc;
  logic [ID_BITS-1:0] ident_new;
  logic [HID_W-1:0]   ident_new_ext;
  logic [HID_W-1:0]   rd_ident_ext;
  logic [HID_W-1:0]   target_ext;
  logic               id_match;
  logic               tk_hit;
  logic               tk_due;
  logic [CNT_W-1:0]   due_cnt_after;
  logic               ex_take;

  // Slot count and interval as the wheel uses them.
  assign slots_use = (slot_count_r == '0) ? SCNT_W'(1) :
                     ((32'(slot_count_r) > MAX_SLOTS) ? SCNT_W'(MAX_SLOTS) : slot_count_r);
  assign interval_use = (interval_r == '0) ? IVL_W'(1) : interval_r;

  assign valid_at = valid_r[idx_r];
  assign due_at   = due_r[idx_r];
  assign age_at   = age_r[idx_r];
  assign idx_last = (idx_r == IDX_W'(MAX_TIMERS - 1));

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  assign div_shift = {rem_r, dq_r[DLY_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_r};
  assign div_ge    = ~div_diff[IVL_W+1];
  assign rem_step  = div_ge ? div_diff[IVL_W-1:0] : div_shift[IVL_W-1:0];
  assign dq_step   = {dq_r[DLY_W-2:0], div_ge};
  assign div_last  = (dcnt_r == DCNT_W'(1));

  // New slot of an add and the slot that follows the current one.
  assign slot_sum  = SUM_W'(cur_r) + SUM_W'(rem_r[SLOT_W-1:0]);
  assign slot_wrap = (slot_sum >= SUM_W'(slots_use)) ? slot_sum - SUM_W'(slots_use) : slot_sum;
  assign cur_inc   = SUM_W'(cur_r) + SUM_W'(1);
  assign cur_wrap  = (cur_inc == SUM_W'(slots_use)) ? '0 : cur_inc;

  // Identifiers wrap and skip zero.
  assign ident_inc     = next_ident_r + ID_BITS'(1);
  assign ident_new     = (ident_inc == '0) ? ID_BITS'(1) : ident_inc;
  assign ident_new_ext = HID_W'(ident_new);
  assign rd_ident_ext  = HID_W'(rd_ident_r);
  assign target_ext    = HID_W'(target_r);
  assign id_match      = (rd_ident_ext == target_ext);

  // Tick visit of one entry.
  assign tk_hit        = valid_at && (rd_slot_r == cur_r);
  assign tk_due        = tk_hit && (rd_rounds_r == '0);
  assign due_cnt_after = tk_due ? due_cnt_r + CNT_W'(1) : due_cnt_r;

  // Newest due entry search, one entry per cycle.
  assign ex_take = due_at && (!best_vld_r || (age_at < best_age_r));

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    free_nxt         = free_r;
    op_nxt           = op_r;
    delay_nxt        = delay_r;
    target_nxt       = target_r;
    cur_nxt          = cur_r;
    current_slot_nxt = current_slot_r;
    next_ident_nxt   = next_ident_r;
    dq_nxt           = dq_r;
    rem_nxt          = rem_r;
    dvs_nxt          = dvs_r;
    dcnt_nxt         = dcnt_r;
    due_cnt_nxt      = due_cnt_r;
    best_nxt         = best_r;
    best_age_nxt     = best_age_r;
    best_vld_nxt     = best_vld_r;
    emit_status_nxt  = emit_status_r;
    emit_handle_nxt  = emit_handle_r;
    out_load         = 1'b0;
    out_load_item    = out_item_r;
    mem_we           = 1'b0;
    mem_waddr        = idx_r;
    mem_wident       = rd_ident_r;
    mem_wslot        = rd_slot_r;
    mem_wrounds      = rd_rounds_r - DLY_W'(1);
    add_en           = 1'b0;
    rel_en           = 1'b0;
    due_set          = 1'b0;
    due_clr          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_item.kind;
          delay_nxt  = in_item.delay_ms;
          target_nxt = in_item.target_id;
          idx_nxt    = '0;
          unique case (in_item.kind)
            KIND_ADD:    state_nxt = ST_FREE;
            KIND_REMOVE: state_nxt = ST_RM_RD;
            KIND_TICK: begin
              dq_nxt    = DLY_W'(current_slot_r) << (DLY_W - SLOT_W);
              rem_nxt   = '0;
              dvs_nxt   = IVL_W'(slots_use);
              dcnt_nxt  = DCNT_W'(SLOT_W);
              state_nxt = ST_MOD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // Lowest free pool entry.
      ST_FREE: begin
        if (!valid_at) begin
          free_nxt  = idx_r;
          dq_nxt    = DLY_W'(current_slot_r) << (DLY_W - SLOT_W);
          rem_nxt   = '0;
          dvs_nxt   = IVL_W'(slots_use);
          dcnt_nxt  = DCNT_W'(SLOT_W);
          state_nxt = ST_MOD;
        end else if (idx_last) begin
          emit_status_nxt = STATUS_POOL_FULL;
          emit_handle_nxt = '0;
          state_nxt       = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // Current slot reduced modulo the slots in use.
      ST_MOD: begin
        dq_nxt   = dq_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (div_last) begin
          cur_nxt = rem_step[SLOT_W-1:0];
          if (op_r == KIND_ADD) begin
            dq_nxt    = delay_r;
            rem_nxt   = '0;
            dvs_nxt   = interval_use;
            dcnt_nxt  = DCNT_W'(DLY_W);
            state_nxt = ST_DIV1;
          end else begin
            idx_nxt     = '0;
            due_cnt_nxt = '0;
            state_nxt   = ST_TK_RD;
          end
        end
      end

      // Ticks of delay: delay / interval.
      ST_DIV1: begin
        dq_nxt   = dq_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (div_last) begin
          rem_nxt   = '0;
          dvs_nxt   = IVL_W'(slots_use);
          dcnt_nxt  = DCNT_W'(DLY_W);
          state_nxt = ST_DIV2;
        end
      end

      // Rotations and slot offset: ticks / slots.
      ST_DIV2: begin
        dq_nxt   = dq_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (div_last) begin
          state_nxt = ST_ADD_WR;
        end
      end

      // Store the new timer and make it the newest.
      ST_ADD_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = free_r;
        mem_wident      = ident_new;
        mem_wslot       = slot_wrap[SLOT_W-1:0];
        mem_wrounds     = dq_r;
        add_en          = 1'b1;
        next_ident_nxt  = ident_new;
        emit_status_nxt = STATUS_ADDED;
        emit_handle_nxt = ident_new_ext[HANDLE_W-1:0];
        state_nxt       = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_load_item.status       = emit_status_r;
          out_load_item.timer_handle = emit_handle_r;
          out_load_item.last         = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end

      ST_RM_RD: state_nxt = ST_RM_CHK;

      // First valid entry with the target identifier.
      ST_RM_CHK: begin
        if (valid_at && id_match) begin
          rel_en          = 1'b1;
          emit_status_nxt = STATUS_REMOVED;
          emit_handle_nxt = target_r;
          state_nxt       = ST_EMIT;
        end else if (idx_last) begin
          emit_status_nxt = STATUS_NOT_FOUND;
          emit_handle_nxt = '0;
          state_nxt       = ST_EMIT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_RM_RD;
        end
      end

      ST_TK_RD: state_nxt = ST_TK_CHK;

      // Timers in the current slot expire or lose one rotation.
      ST_TK_CHK: begin
        if (tk_due) begin
          due_set = 1'b1;
        end else if (tk_hit) begin
          mem_we = 1'b1;
        end
        due_cnt_nxt = due_cnt_after;
        if (idx_last) begin
          current_slot_nxt = cur_wrap[SLOT_W-1:0];
          idx_nxt          = '0;
          best_vld_nxt     = 1'b0;
          state_nxt        = (due_cnt_after != '0) ? ST_EX_SCAN : ST_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_TK_RD;
        end
      end

      // Find the newest due timer.
      ST_EX_SCAN: begin
        if (ex_take) begin
          best_nxt     = idx_r;
          best_age_nxt = age_at;
          best_vld_nxt = 1'b1;
        end
        if (idx_last) begin
          idx_nxt   = ex_take ? idx_r : best_r;
          state_nxt = ST_EX_RD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_EX_RD: state_nxt = ST_EX_OUT;

      // Report and free the expired timer.
      ST_EX_OUT: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_load_item.status       = STATUS_EXPIRED;
          out_load_item.timer_handle = rd_ident_ext[HANDLE_W-1:0];
          out_load_item.last         = (due_cnt_r == CNT_W'(1));
          rel_en                     = 1'b1;
          due_clr                    = 1'b1;
          due_cnt_nxt                = due_cnt_r - CNT_W'(1);
          idx_nxt                    = '0;
          best_vld_nxt               = 1'b0;
          state_nxt = (due_cnt_r == CNT_W'(1)) ? ST_IDLE : ST_EX_SCAN;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register hand-off.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = out_load_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Per-entry valid, due and age updates.
  always_comb begin
    valid_nxt = valid_r;
    due_nxt   = due_r;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      age_nxt[i] = age_r[i];
      if (add_en) begin
        if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + IDX_W'(1);
        end
        if (IDX_W'(i) == free_r) begin
          valid_nxt[i] = 1'b1;
          age_nxt[i]   = '0;
        end
      end
      if (rel_en) begin
        if (valid_r[i] && (age_r[i] > age_at)) begin
          age_nxt[i] = age_r[i] - IDX_W'(1);
        end
        if (IDX_W'(i) == idx_r) begin
          valid_nxt[i] = 1'b0;
        end
      end
      if (due_set && (IDX_W'(i) == idx_r)) begin
        due_nxt[i] = 1'b1;
      end
      if (due_clr && (IDX_W'(i) == idx_r)) begin
        due_nxt[i] = 1'b0;
      end
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      slot_count_r   <= SLOT_COUNT_RST;
      interval_r     <= SLOT_INTERVAL_RST;
      current_slot_r <= '0;
      next_ident_r   <= '0;
      valid_r        <= '0;
      due_r          <= '0;
      due_cnt_r      <= '0;
      best_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      current_slot_r <= current_slot_nxt;
      next_ident_r   <= next_ident_nxt;
      valid_r        <= valid_nxt;
      due_r          <= due_nxt;
      due_cnt_r      <= due_cnt_nxt;
      best_vld_r     <= best_vld_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLOT_COUNT:    slot_count_r <= cfg_wdata[SCNT_W-1:0];
          CFG_SLOT_INTERVAL: interval_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    free_r        <= free_nxt;
    op_r          <= op_nxt;
    delay_r       <= delay_nxt;
    target_r      <= target_nxt;
    cur_r         <= cur_nxt;
    dq_r          <= dq_nxt;
    rem_r         <= rem_nxt;
    dvs_r         <= dvs_nxt;
    dcnt_r        <= dcnt_nxt;
    best_r        <= best_nxt;
    best_age_r    <= best_age_nxt;
    emit_status_r <= emit_status_nxt;
    emit_handle_r <= emit_handle_nxt;
    out_item_r    <= out_item_nxt;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      age_r[i] <= age_nxt[i];
    end
  end

  // Timer pool memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_ident[mem_waddr]  <= mem_wident;
      mem_slot[mem_waddr]   <= mem_wslot;
      mem_rounds[mem_waddr] <= mem_wrounds;
    end
    rd_ident_r  <= mem_ident[idx_r];
    rd_slot_r   <= mem_slot[idx_r];
    rd_rounds_r <= mem_rounds[idx_r];
  end

endmodule
